@@ hw/rtl/hdcc_pkg.sv @@
// Package for the hue depth color codec: hue index type and the fixed
// constants of the 1530-step hue wheel and the 16-bit depth scaling.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hdcc_pkg;

	// Hue index on the wheel, 0 to 1529.
	typedef logic [10:0] hue_t;

	// Operation codes carried by the op field.
	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	// Wheel geometry.
	localparam hue_t HUE_STEPS = 11'd1529;
	localparam hue_t SEG_1     = 11'd255;
	localparam hue_t SEG_2     = 11'd510;
	localparam hue_t SEG_3     = 11'd765;
	localparam hue_t SEG_4     = 11'd1020;
	localparam hue_t SEG_5     = 11'd1275;

	// Encode scaling: floor(depth*1529 + 32767) / 65535, width of the product.
	localparam int ENC_PROD_W = 27;
	localparam logic [ENC_PROD_W-1:0] ENC_MUL  = 27'd1529;
	localparam logic [ENC_PROD_W-1:0] ENC_BIAS = 27'd32767;
	localparam logic [16:0] DEPTH_MAX = 17'd65535;

	// Decode scaling: h*65535/1529 = 42*h + (1317*h)/1529, rounded.
	localparam int DEC_X_W = 21;
	localparam logic [15:0] DEC_WHOLE = 16'd42;
	localparam logic [DEC_X_W-1:0] DEC_FRAC = 21'd1317;
	localparam logic [DEC_X_W-1:0] DEC_BIAS = 21'd764;
	// ceil(2^32 / 1529); exact quotient for any numerator below 2^21.
	localparam int DEC_PROD_W = 43;
	localparam logic [DEC_PROD_W-1:0] DEC_RECIP = 43'd2809005;

	// Decode gives zero below this channel sum.
	localparam logic [9:0] DARK_LIMIT = 10'd255;

endpackage

`default_nettype wire

@@ hw/rtl/hdcc_hue_ramp.sv @@
// Hue ramp: maps a hue index to an RGB color on the six-segment wheel.
// Depends on hdcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hdcc_hue_ramp (
	input  wire hdcc_pkg::hue_t hue,
	output logic [7:0]          red,
	output logic [7:0]          green,
	output logic [7:0]          blue
);
	import hdcc_pkg::*;

	hue_t red_w;
	hue_t green_w;
	hue_t blue_w;

	// Each channel is a plateau, a rising or falling ramp, or zero.
	always_comb begin
		if (hue <= SEG_1 || hue > SEG_5) begin
			red_w = SEG_1;
		end else if (hue <= SEG_2) begin
			red_w = SEG_2 - hue;
		end else if (hue <= SEG_4) begin
			red_w = '0;
		end else begin
			red_w = hue - SEG_4;
		end

		if (hue <= SEG_1) begin
			green_w = hue;
		end else if (hue <= SEG_3) begin
			green_w = SEG_1;
		end else if (hue <= SEG_4) begin
			green_w = SEG_4 - hue;
		end else begin
			green_w = '0;
		end

		if (hue <= SEG_2) begin
			blue_w = '0;
		end else if (hue <= SEG_3) begin
			blue_w = hue - SEG_2;
		end else if (hue <= SEG_5) begin
			blue_w = SEG_1;
		end else begin
			blue_w = HUE_STEPS - hue;
		end
	end

	assign red   = red_w[7:0];
	assign green = green_w[7:0];
	assign blue  = blue_w[7:0];

endmodule

`default_nettype wire

@@ hw/rtl/hdcc_hue_detect.sv @@
// Hue detection: picks the dominant channel of a color and forms its hue
// index, and flags colors too dark to decode. Depends on hdcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hdcc_hue_detect (
	input  wire [7:0]            red,
	input  wire [7:0]            green,
	input  wire [7:0]            blue,
	output hdcc_pkg::hue_t       hue,
	output logic                 dark
);
	import hdcc_pkg::*;

	hue_t r_w;
	hue_t g_w;
	hue_t b_w;
	logic [9:0] sum_w;

	assign r_w = {3'b000, red};
	assign g_w = {3'b000, green};
	assign b_w = {3'b000, blue};

	// Channel sum for the dark test.
	assign sum_w = {2'b00, red} + {2'b00, green} + {2'b00, blue};
	assign dark  = (sum_w < DARK_LIMIT);

	// Red wins ties, then green; wrap-around in red's segment adds a turn.
	always_comb begin
		if (red >= green && red >= blue) begin
			if (green >= blue) begin
				hue = g_w - b_w;
			end else begin
				hue = HUE_STEPS + g_w - b_w;
			end
		end else if (green >= red && green >= blue) begin
			hue = SEG_2 + b_w - r_w;
		end else begin
			hue = SEG_4 + r_w - g_w;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/hue_depth_color_codec.sv @@
// Top level of the hue depth color codec: four-stage pipeline with
// handshake control. Depends on hdcc_pkg, hdcc_hue_ramp and hdcc_hue_detect.
`timescale 1ns / 1ps
`default_nettype none

// Converts a 16-bit depth to a color on a 1530-step hue wheel (op = 0) or a
// color back to depth (op = 1). One transaction can enter on every clock
// cycle while in_ready is high; the pipeline has four register stages set
// by the scaling multiplies, and each stage fills a bubble on its own, so
// a stall at the output holds items without loss. Fields of the unused
// direction read as zero.
module hue_depth_color_codec (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire        op,
	input  wire [15:0] depth,
	input  wire [7:0]  red,
	input  wire [7:0]  green,
	input  wire [7:0]  blue,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [15:0] depth_out,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out
);
	import hdcc_pkg::*;

	// Stage valids and enables.
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	// Stage 1: encode product, decode hue.
	logic                  op_s1;
	logic [ENC_PROD_W-1:0] m_s1;
	hue_t                  h_s1;
	logic                  dark_s1;

	// Stage 2: encode hue index, decode fraction numerator.
	logic               op_s2;
	hue_t               d_s2;
	logic [DEC_X_W-1:0] x_s2;
	logic [15:0]        base_s2;
	logic               dark_s2;

	// Stage 3: encode color, decode quotient.
	logic        op_s3;
	logic [7:0]  r_s3, g_s3, b_s3;
	hue_t        quo_s3;
	logic [15:0] base_s3;
	logic        dark_s3;

	// Stage 4: output register.
	logic [15:0] depth_s4;
	logic [7:0]  r_s4, g_s4, b_s4;

	hue_t                  h_w;
	logic                  dark_w;
	logic [ENC_PROD_W-1:0] m_w;
	hue_t                  q0_w;
	logic [16:0]           rsum_w;
	logic [7:0]            ramp_r_w, ramp_g_w, ramp_b_w;
	logic [DEC_PROD_W-1:0] prod_w;

	// Each stage moves when it is empty or the next one moves.
	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 1 logic: depth times 1529 plus half a step, and hue detection.
	assign m_w = {11'd0, depth} * ENC_MUL + ENC_BIAS;

	hdcc_hue_detect u_detect (
		.red   (red),
		.green (green),
		.blue  (blue),
		.hue   (h_w),
		.dark  (dark_w)
	);

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			op_s1   <= op;
			m_s1    <= m_w;
			h_s1    <= h_w;
			dark_s1 <= dark_w;
		end
	end

	// Stage 2 logic: divide by 65535 as high half plus a one-step correction.
	assign q0_w   = m_s1[ENC_PROD_W-1:16];
	assign rsum_w = {6'd0, q0_w} + {1'b0, m_s1[15:0]};

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			op_s2   <= op_s1;
			d_s2    <= (rsum_w >= DEPTH_MAX) ? q0_w + 11'd1 : q0_w;
			x_s2    <= {10'd0, h_s1} * DEC_FRAC + DEC_BIAS;
			base_s2 <= {5'd0, h_s1} * DEC_WHOLE;
			dark_s2 <= dark_s1;
		end
	end

	// Stage 3 logic: hue ramp, and division by 1529 through its reciprocal.
	hdcc_hue_ramp u_ramp (
		.hue   (d_s2),
		.red   (ramp_r_w),
		.green (ramp_g_w),
		.blue  (ramp_b_w)
	);

	assign prod_w = {22'd0, x_s2} * DEC_RECIP;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			op_s3   <= op_s2;
			r_s3    <= ramp_r_w;
			g_s3    <= ramp_g_w;
			b_s3    <= ramp_b_w;
			quo_s3  <= prod_w[DEC_PROD_W-1:32];
			base_s3 <= base_s2;
			dark_s3 <= dark_s2;
		end
	end

	// Stage 4 logic: final depth sum and zeroing of the unused direction.
	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			if (op_s3 == OP_DECODE) begin
				depth_s4 <= dark_s3 ? 16'd0 : base_s3 + {5'd0, quo_s3};
				r_s4     <= 8'd0;
				g_s4     <= 8'd0;
				b_s4     <= 8'd0;
			end else begin
				depth_s4 <= 16'd0;
				r_s4     <= r_s3;
				g_s4     <= g_s3;
				b_s4     <= b_s3;
			end
		end
	end

	assign out_valid = v_s4;
	assign depth_out = depth_s4;
	assign red_out   = r_s4;
	assign green_out = g_s4;
	assign blue_out  = b_s4;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the hue depth color codec: a directed table,
// then random transactions with random gaps on both handshakes.
// Depends on hdcc_pkg and hue_depth_color_codec.
`timescale 1ns / 1ps

module testbench;
	import hdcc_pkg::*;

	// Hue wheel span and full-scale depth used by the scaling arithmetic.
	localparam int unsigned WHEEL_SPAN = 1529;
	localparam int unsigned DEPTH_SPAN = 65535;
	localparam int unsigned DARK_SUM = 255;
	localparam int NUM_DIRECTED = 24;
	localparam int NUM_RANDOM = 650;
	localparam int DRAIN_CYCLES = 20;
	localparam int IDLE_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	// One result of the codec.
	typedef struct packed {
		logic [15:0] depth_out;
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
	} pixel_out_t;

	// One row of the directed table; the result fields are used only when typed is set.
	typedef struct packed {
		logic        op;
		logic [15:0] depth;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		bit          typed;
		logic [15:0] exp_depth;
		logic [7:0]  exp_red;
		logic [7:0]  exp_green;
		logic [7:0]  exp_blue;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = OP_ENCODE;
	logic [15:0] depth = 16'd0;
	logic [7:0]  red = 8'd0;
	logic [7:0]  green = 8'd0;
	logic [7:0]  blue = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] depth_out;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;

	pixel_out_t pending_pixels [$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	int sink_cycle = 0;
	bit feed_calm = 1'b0;

	// Extremes, segment boundaries, ties between channels and dark colors.
	stim_row_t directed_rows [NUM_DIRECTED] = '{
		'{OP_ENCODE, 16'd0,     8'hFF, 8'hFF, 8'hFF, 1'b1, 16'd0, 8'd255, 8'd0, 8'd0},
		'{OP_ENCODE, 16'd65535, 8'hFF, 8'h00, 8'hFF, 1'b1, 16'd0, 8'd255, 8'd0, 8'd0},
		'{OP_ENCODE, 16'd10929, 8'h00, 8'h00, 8'h00, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_ENCODE, 16'd10951, 8'h5A, 8'hA5, 8'h3C, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_ENCODE, 16'd21859, 8'h00, 8'h00, 8'h00, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_ENCODE, 16'd21880, 8'h00, 8'h00, 8'h00, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_ENCODE, 16'd32768, 8'h00, 8'h00, 8'h00, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_ENCODE, 16'd43690, 8'h00, 8'h00, 8'h00, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_ENCODE, 16'd43720, 8'h00, 8'h00, 8'h00, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_ENCODE, 16'd54613, 8'h00, 8'h00, 8'h00, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_ENCODE, 16'd54650, 8'h00, 8'h00, 8'h00, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_ENCODE, 16'h5555,  8'h00, 8'h00, 8'h00, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_ENCODE, 16'hAAAA,  8'hFF, 8'hFF, 8'hFF, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_DECODE, 16'hFFFF,  8'd0,   8'd0,   8'd0,   1'b1, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_DECODE, 16'hFFFF,  8'd100, 8'd100, 8'd54,  1'b1, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_DECODE, 16'h0000,  8'd255, 8'd0,   8'd0,   1'b1, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_DECODE, 16'h1234,  8'd255, 8'd255, 8'd255, 1'b1, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_DECODE, 16'h0000,  8'd255, 8'd0,   8'd10,  1'b0, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_DECODE, 16'hFFFF,  8'd0,   8'd255, 8'd0,   1'b0, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_DECODE, 16'h0000,  8'd0,   8'd0,   8'd255, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_DECODE, 16'h8001,  8'd85,  8'd0,   8'd170, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_DECODE, 16'h0000,  8'd255, 8'd255, 8'd0,   1'b0, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_DECODE, 16'h7FFE,  8'd0,   8'd255, 8'd255, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0},
		'{OP_DECODE, 16'h0000,  8'd255, 8'd0,   8'd255, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0}
	};

	hue_depth_color_codec dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.depth     (depth),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.depth_out (depth_out),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Computes the codec result for one transaction; fields of the other direction stay zero.
	function automatic pixel_out_t convert_pixel(input logic op_i, input logic [15:0] depth_i,
			input logic [7:0] red_i, input logic [7:0] green_i, input logic [7:0] blue_i);
		pixel_out_t res;
		int unsigned idx;
		int unsigned hue;
		int unsigned rv;
		int unsigned gv;
		int unsigned bv;
		res = '0;
		rv = 32'(red_i);
		gv = 32'(green_i);
		bv = 32'(blue_i);
		if (op_i == OP_ENCODE) begin
			idx = (2 * int'(depth_i) * WHEEL_SPAN + DEPTH_SPAN) / (2 * DEPTH_SPAN);
			// Six-segment ramp around the wheel.
			if (idx <= 32'(SEG_1) || idx > 32'(SEG_5))
				res.red_out = 8'd255;
			else if (idx <= 32'(SEG_2))
				res.red_out = 8'(32'(SEG_2) - idx);
			else if (idx <= 32'(SEG_4))
				res.red_out = 8'd0;
			else
				res.red_out = 8'(idx - 32'(SEG_4));
			if (idx <= 32'(SEG_1))
				res.green_out = 8'(idx);
			else if (idx <= 32'(SEG_3))
				res.green_out = 8'd255;
			else if (idx <= 32'(SEG_4))
				res.green_out = 8'(32'(SEG_4) - idx);
			else
				res.green_out = 8'd0;
			if (idx <= 32'(SEG_2))
				res.blue_out = 8'd0;
			else if (idx <= 32'(SEG_3))
				res.blue_out = 8'(idx - 32'(SEG_2));
			else if (idx <= 32'(SEG_5))
				res.blue_out = 8'd255;
			else
				res.blue_out = 8'(WHEEL_SPAN - idx);
		end else if (rv + gv + bv >= DARK_SUM) begin
			// Dominant channel picks the hue, red winning ties, then green.
			if (rv >= gv && rv >= bv)
				hue = (gv >= bv) ? gv - bv : WHEEL_SPAN + gv - bv;
			else if (gv >= rv && gv >= bv)
				hue = 32'(SEG_2) + bv - rv;
			else
				hue = 32'(SEG_4) + rv - gv;
			res.depth_out = 16'((2 * hue * DEPTH_SPAN + WHEEL_SPAN) / (2 * WHEEL_SPAN));
		end
		return res;
	endfunction

	// Gap before a transaction: mostly none, some short, a few long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (feed_calm || roll < 60)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Presents one transaction and records its expected result once it is accepted.
	task automatic send_pixel(input logic op_i, input logic [15:0] depth_i, input logic [7:0] red_i,
			input logic [7:0] green_i, input logic [7:0] blue_i, input pixel_out_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= op_i;
		depth <= depth_i;
		red <= red_i;
		green <= green_i;
		blue <= blue_i;
		do
			@(posedge clk);
		while (!in_ready);
		pending_pixels.push_back(want);
	endtask

	// Stimulus: reset, the directed table, then random transactions.
	initial begin
		stim_row_t row;
		pixel_out_t want;
		pixel_out_t ramp;
		logic op_r;
		logic [15:0] depth_r;
		logic [7:0] red_r;
		logic [7:0] green_r;
		logic [7:0] blue_r;
		int mode;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			row = directed_rows[i];
			if (row.typed)
				want = '{row.exp_depth, row.exp_red, row.exp_green, row.exp_blue};
			else
				want = convert_pixel(row.op, row.depth, row.red, row.green, row.blue);
			send_pixel(row.op, row.depth, row.red, row.green, row.blue, want);
		end

		for (int i = 0; i < NUM_RANDOM; i++) begin
			feed_calm = ((i / 80) % 2) == 1;
			mode = $urandom_range(0, 9);
			depth_r = 16'($urandom_range(0, 65535));
			red_r = 8'($urandom_range(0, 255));
			green_r = 8'($urandom_range(0, 255));
			blue_r = 8'($urandom_range(0, 255));
			if (mode < 4) begin
				op_r = OP_ENCODE;
				// Some depths sit at the ends of the range.
				if (mode == 0)
					depth_r = ($urandom_range(0, 1) != 0) ? 16'(65535 - $urandom_range(0, 40))
						: 16'($urandom_range(0, 40));
			end else begin
				op_r = OP_DECODE;
				if (mode < 7) begin
					// Colors that lie on the ramp, as the encoder produces them.
					ramp = convert_pixel(OP_ENCODE, 16'($urandom_range(0, 65535)), 8'd0, 8'd0, 8'd0);
					red_r = ramp.red_out;
					green_r = ramp.green_out;
					blue_r = ramp.blue_out;
				end else if (mode == 7) begin
					// Dim colors around the dark threshold.
					red_r = 8'($urandom_range(0, 127));
					green_r = 8'($urandom_range(0, 127));
					blue_r = 8'($urandom_range(0, 127));
				end
			end
			send_pixel(op_r, depth_r, red_r, green_r, blue_r,
				convert_pixel(op_r, depth_r, red_r, green_r, blue_r));
		end
		in_valid <= 1'b0;

		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Output backpressure: long ready stretches alternate with random stalls.
	always @(posedge clk) begin
		sink_cycle <= sink_cycle + 1;
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ((sink_cycle / 600) % 3 == 1) begin
			out_ready <= 1'b1;
		end else begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: begin
					out_ready <= 1'b0;
					stall_left <= $urandom_range(0, 3);
				end
				4: begin
					out_ready <= 1'b0;
					stall_left <= $urandom_range(8, 40);
				end
				default: begin
					out_ready <= 1'b1;
				end
			endcase
		end
	end

	// Each result transaction is compared with the oldest expectation.
	always @(posedge clk) begin
		pixel_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("Unexpected result: depth %0d rgb %0d %0d %0d",
						depth_out, red_out, green_out, blue_out);
			end else begin
				want = pending_pixels.pop_front();
				if (depth_out !== want.depth_out || red_out !== want.red_out
						|| green_out !== want.green_out || blue_out !== want.blue_out) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("Mismatch: expected depth %0d rgb %0d %0d %0d, got depth %0d rgb %0d %0d %0d",
							want.depth_out, want.red_out, want.green_out, want.blue_out,
							depth_out, red_out, green_out, blue_out);
				end
			end
		end
	end

	// Watchdog: too many cycles without any transaction on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
